// ===== rtl/nrtl_pkg.sv =====
// shared types and codes for the translation rule table
package nrtl_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_PORT  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic [1:0] STATUS_STORED = 2'd0;
	localparam logic [1:0] STATUS_DUP    = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [1:0]  rule_kind;
		logic [31:0] key_address;
		logic [15:0] key_port;
		logic [31:0] target_address;
		logic [15:0] target_port;
	} req_t;

	typedef struct packed {
		logic [1:0]  match_kind;
		logic [1:0]  insert_status;
		logic [31:0] echo_address;
		logic [15:0] echo_port;
		logic [31:0] mapped_address;
		logic [15:0] mapped_port;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [15:0] port;
	} rule_key_t;

	typedef struct packed {
		rule_key_t   key;
		logic [31:0] target_address;
		logic [15:0] target_port;
	} rule_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
	} match_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/nrtl_rule_mem.sv =====
// rule storage, one write and one registered read per cycle
module nrtl_rule_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  nrtl_pkg::rule_t     wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output nrtl_pkg::rule_t     rd_data
);

	nrtl_pkg::rule_t mem_q [DEPTH];
	nrtl_pkg::rule_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/nrtl_match.sv =====
// key compare unit shared by duplicate check and lookup scan
module nrtl_match (
	input  logic                operation,
	input  nrtl_pkg::rule_key_t probe,
	input  nrtl_pkg::rule_key_t entry,
	output nrtl_pkg::match_t    result
);

	logic addr_eq;
	logic port_eq;
	logic wild_hit;

	assign addr_eq = (entry.address == probe.address);
	assign port_eq = (entry.port == probe.port);

	// stored keys already hold zero in the ignored part
	always_comb begin
		unique case (entry.kind)
			nrtl_pkg::KIND_EXACT: wild_hit = addr_eq && port_eq;
			nrtl_pkg::KIND_ADDR:  wild_hit = addr_eq;
			nrtl_pkg::KIND_PORT:  wild_hit = port_eq;
			default:              wild_hit = 1'b0;
		endcase
	end

	always_comb begin
		result.kind = entry.kind;
		if (operation == nrtl_pkg::OP_INSERT) begin
			result.hit = (entry.kind == probe.kind) && addr_eq && port_eq;
		end else begin
			result.hit = wild_hit;
		end
	end

endmodule

// ===== rtl/nat_rule_table_lookup.sv =====
// translation rule table: insert with duplicate check, wildcard lookup
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | nrtl_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_ready  | nrtl_pkg::rsp_t
//
// Every item scans the stored rules once, one rule per cycle through the
// single read port of the rule memory and one shared key comparator.
// An item runs through the scan and ST_LAST (both skipped with an empty table)
// to ST_DONE, which loads its result into the output register; req_ready stays
// low for the whole scan and rises with rsp_valid, so items do not overlap.
// Reset empties the table at once (rule count to zero), no clearing pass.
// A result waits in the output register; a stalled rsp holds the block in its
// final state until the register is free.
module nat_rule_table_lookup #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  nrtl_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output nrtl_pkg::rsp_t   rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	nrtl_pkg::state_t    state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic                rd_pending_s1;
	logic                op_q;
	nrtl_pkg::rule_key_t probe_q;
	logic [31:0]         raw_addr_q;
	logic [15:0]         raw_port_q;
	logic [31:0]         tgt_addr_q;
	logic [15:0]         tgt_port_q;
	logic                best_hit_q;
	logic [1:0]          best_kind_q;
	logic [31:0]         best_addr_q;
	logic [15:0]         best_port_q;
	logic                rsp_valid_q;
	nrtl_pkg::rsp_t      rsp_q;

	logic                accept;
	logic                rd_en;
	logic                wr_en;
	logic                rsp_load;
	logic                last_idx;
	logic                full;
	nrtl_pkg::rule_t     wr_rule;
	nrtl_pkg::rule_t     rd_rule;
	nrtl_pkg::match_t    match;
	nrtl_pkg::rule_key_t req_key;
	nrtl_pkg::rsp_t      rsp_d;

	assign accept   = req_valid && req_ready;
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign full     = (count_q == CNT_W'(TABLE_ENTRIES));

	// insert keys drop the part the rule kind ignores
	always_comb begin
		req_key.kind    = req.rule_kind;
		req_key.address = req.key_address;
		req_key.port    = req.key_port;
		if (req.operation == nrtl_pkg::OP_INSERT) begin
			if (req.rule_kind == nrtl_pkg::KIND_ADDR) begin
				req_key.port = '0;
			end else if (req.rule_kind == nrtl_pkg::KIND_PORT) begin
				req_key.address = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrtl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			nrtl_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (count_q == '0) ? nrtl_pkg::ST_DONE : nrtl_pkg::ST_SCAN;
				end
			end
			nrtl_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (last_idx) begin
					state_d = nrtl_pkg::ST_LAST;
				end
			end
			nrtl_pkg::ST_LAST: begin
				state_d = nrtl_pkg::ST_DONE;
			end
			nrtl_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = nrtl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nrtl_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_en = rsp_load && (op_q == nrtl_pkg::OP_INSERT) &&
		(probe_q.kind != nrtl_pkg::KIND_NONE) && !best_hit_q && !full;

	always_comb begin
		wr_rule.key            = probe_q;
		wr_rule.target_address = tgt_addr_q;
		wr_rule.target_port    = tgt_port_q;
	end

	nrtl_rule_mem #(
		.DEPTH (TABLE_ENTRIES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_rule),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_rule)
	);

	nrtl_match u_match (
		.operation (op_q),
		.probe     (probe_q),
		.entry     (rd_rule.key),
		.result    (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			idx_q         <= '0;
			rd_pending_s1 <= 1'b0;
			best_hit_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			rd_pending_s1 <= rd_en;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			// lower kind code wins; earlier rule wins within a kind
			if (accept) begin
				best_hit_q <= 1'b0;
			end else if (rd_pending_s1 && match.hit &&
				(!best_hit_q || (match.kind < best_kind_q))) begin
				best_hit_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.operation;
			probe_q    <= req_key;
			raw_addr_q <= req.key_address;
			raw_port_q <= req.key_port;
			tgt_addr_q <= req.target_address;
			tgt_port_q <= req.target_port;
		end
		if (rd_pending_s1 && match.hit && (!best_hit_q || (match.kind < best_kind_q))) begin
			best_kind_q <= match.kind;
			best_addr_q <= rd_rule.target_address;
			best_port_q <= rd_rule.target_port;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		rsp_d = '0;
		if (op_q == nrtl_pkg::OP_LOOKUP) begin
			rsp_d.match_kind    = best_hit_q ? best_kind_q : nrtl_pkg::KIND_NONE;
			rsp_d.insert_status = nrtl_pkg::STATUS_STORED;
			rsp_d.echo_address  = raw_addr_q;
			rsp_d.echo_port     = raw_port_q;
			if (best_hit_q) begin
				rsp_d.mapped_address = best_addr_q;
				rsp_d.mapped_port    = best_port_q;
			end
		end else begin
			rsp_d.match_kind   = nrtl_pkg::KIND_NONE;
			rsp_d.echo_address = probe_q.address;
			rsp_d.echo_port    = probe_q.port;
			if (probe_q.kind == nrtl_pkg::KIND_NONE || best_hit_q) begin
				rsp_d.insert_status = nrtl_pkg::STATUS_DUP;
			end else if (full) begin
				rsp_d.insert_status = nrtl_pkg::STATUS_FULL;
			end else begin
				rsp_d.insert_status = nrtl_pkg::STATUS_STORED;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("rule count past table size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("new transfer taken during scan");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("rule write without count step");

	a_write_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (op_q == nrtl_pkg::OP_INSERT) && (state_q == nrtl_pkg::ST_DONE))
		else $error("rule write outside insert completion");

	a_load_after_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_valid && (state_q == nrtl_pkg::ST_IDLE))
		else $error("result load did not present");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench for the translation rule table: directed and random traffic checked by a table model
module tb;

	localparam int TABLE_DEPTH = 64;
	localparam int POOL_SIZE   = 16;
	localparam int HOLD_CYCLES = 300;

	class rule_table_model #(int DEPTH = 64);
		nrtl_pkg::rule_t rules[DEPTH];
		int              rule_count;
		nrtl_pkg::rsp_t  expected_results[$];
		int              mismatches;

		function int find_rule(nrtl_pkg::rule_key_t key);
			for (int i = 0; i < rule_count; i++) begin
				if (rules[i].key == key)
					return i;
			end
			return -1;
		endfunction

		function nrtl_pkg::rsp_t translate(nrtl_pkg::req_t r);
			nrtl_pkg::rsp_t      res;
			nrtl_pkg::rule_key_t key;
			int                  idx;
			res = '0;
			res.match_kind = nrtl_pkg::KIND_NONE;
			res.insert_status = nrtl_pkg::STATUS_STORED;
			res.echo_address = r.key_address;
			res.echo_port = r.key_port;
			if (r.operation == nrtl_pkg::OP_INSERT) begin
				key = '{kind: r.rule_kind, address: r.key_address, port: r.key_port};
				// wildcard part of the key is stored as zero
				if (r.rule_kind == nrtl_pkg::KIND_ADDR)
					key.port = '0;
				else if (r.rule_kind == nrtl_pkg::KIND_PORT)
					key.address = '0;
				res.echo_address = key.address;
				res.echo_port = key.port;
				if (r.rule_kind == nrtl_pkg::KIND_NONE || find_rule(key) >= 0) begin
					res.insert_status = nrtl_pkg::STATUS_DUP;
				end else if (rule_count >= DEPTH) begin
					res.insert_status = nrtl_pkg::STATUS_FULL;
				end else begin
					rules[rule_count] = '{key: key, target_address: r.target_address,
						target_port: r.target_port};
					rule_count++;
				end
			end else begin
				// exact first, then address-only, then port-only
				key = '{kind: nrtl_pkg::KIND_EXACT, address: r.key_address, port: r.key_port};
				idx = find_rule(key);
				if (idx < 0) begin
					key = '{kind: nrtl_pkg::KIND_ADDR, address: r.key_address, port: 16'h0};
					idx = find_rule(key);
				end
				if (idx < 0) begin
					key = '{kind: nrtl_pkg::KIND_PORT, address: 32'h0, port: r.key_port};
					idx = find_rule(key);
				end
				if (idx >= 0) begin
					res.match_kind = key.kind;
					res.mapped_address = rules[idx].target_address;
					res.mapped_port = rules[idx].target_port;
				end
			end
			return res;
		endfunction

		function void note_request(nrtl_pkg::req_t r);
			expected_results = {expected_results, translate(r)};
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(nrtl_pkg::rsp_t got);
			nrtl_pkg::rsp_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing pending: expected none, got %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			compare("match_kind", 32'(want.match_kind), 32'(got.match_kind));
			compare("insert_status", 32'(want.insert_status), 32'(got.insert_status));
			compare("echo_address", want.echo_address, got.echo_address);
			compare("echo_port", 32'(want.echo_port), 32'(got.echo_port));
			compare("mapped_address", want.mapped_address, got.mapped_address);
			compare("mapped_port", 32'(want.mapped_port), 32'(got.mapped_port));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	nrtl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	nrtl_pkg::rsp_t rsp;

	rule_table_model #(TABLE_DEPTH) model = new;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked = 0;
	int holds_granted = 0;
	logic [31:0] addr_pool[POOL_SIZE];
	logic [15:0] port_pool[POOL_SIZE];

	nat_rule_table_lookup #(.TABLE_ENTRIES(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// response side: random backpressure plus an occasional long hold
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				model.check_result(rsp);
			if (holds_granted != holds_asked) begin
				holds_granted++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic nrtl_pkg::req_t make_item(logic op, logic [1:0] kind,
		logic [31:0] addr, logic [15:0] port, logic [31:0] taddr, logic [15:0] tport);
		nrtl_pkg::req_t item;
		item.operation = op;
		item.rule_kind = kind;
		item.key_address = addr;
		item.key_port = port;
		item.target_address = taddr;
		item.target_port = tport;
		return item;
	endfunction

	task automatic send_item(input nrtl_pkg::req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		model.note_request(item);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (model.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_items(input int count);
		nrtl_pkg::req_t item;
		repeat (count) begin
			item.operation = ($urandom_range(99) < 45) ? nrtl_pkg::OP_INSERT :
				nrtl_pkg::OP_LOOKUP;
			if (item.operation == nrtl_pkg::OP_INSERT)
				item.rule_kind = ($urandom_range(99) < 5) ? nrtl_pkg::KIND_NONE :
					2'($urandom_range(2));
			else
				item.rule_kind = 2'($urandom);
			// mostly keys from a small pool so lookups hit and inserts collide
			item.key_address = ($urandom_range(99) < 80) ?
				addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
			item.key_port = ($urandom_range(99) < 80) ?
				port_pool[$urandom_range(POOL_SIZE - 1)] : 16'($urandom);
			item.target_address = $urandom;
			item.target_port = 16'($urandom);
			send_item(item);
		end
	endtask

	initial begin
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hffff_ffff;
		addr_pool[2] = 32'hc0a8_0001;
		port_pool[0] = 16'h0;
		port_pool[1] = 16'hffff;
		port_pool[2] = 16'h8080;
		for (int i = 3; i < POOL_SIZE; i++) begin
			addr_pool[i] = $urandom;
			port_pool[i] = 16'($urandom);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 49;
		// lookup on an empty table, unused fields at their extremes
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_NONE, 32'hffff_ffff, 16'hffff,
			32'hffff_ffff, 16'hffff));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, 32'h0, 16'h0,
			32'hffff_ffff, 16'hffff));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, 32'hffff_ffff, 16'hffff,
			32'h0, 16'h0));
		// wildcard part of the key given as nonzero
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_ADDR, 32'hc0a8_0001, 16'h1234,
			32'h0a00_0001, 16'h0050));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_PORT, 32'hdead_beef, 16'h8080,
			32'h0a00_0002, 16'h1f90));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_PORT, 32'h0, 16'hffff,
			32'h5555_aaaa, 16'haaaa));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_ADDR, 32'hffff_ffff, 16'hffff,
			32'haaaa_5555, 16'h5555));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_NONE, 32'h1, 16'h1,
			32'h1, 16'h1));
		// duplicates keep the first target
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, 32'h0, 16'h0,
			32'h1234_5678, 16'h4321));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_ADDR, 32'hc0a8_0001, 16'h9999,
			32'h8765_4321, 16'h0001));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_PORT, 32'h1, 16'h8080,
			32'h0bad_f00d, 16'h0002));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_EXACT, 32'h0, 16'h0,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_EXACT, 32'hffff_ffff, 16'hffff,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_PORT, 32'hffff_ffff, 16'h0001,
			32'hffff_ffff, 16'hffff));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_ADDR, 32'h1234_5678, 16'hffff,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_NONE, 32'hc0a8_0001, 16'h8080,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_EXACT, 32'h0, 16'h0001,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_EXACT, 32'h0a0a_0a0a, 16'h8080,
			$urandom, 16'($urandom)));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_ADDR, 32'hc0a8_0001, 16'h0,
			32'hffff_ffff, 16'h0));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_NONE, 32'hffff_ffff, 16'hffff,
			32'hffff_ffff, 16'hffff));
		send_item(make_item(nrtl_pkg::OP_LOOKUP, nrtl_pkg::KIND_EXACT, 32'h0, 16'hffff,
			32'h0, 16'h0));

		random_items(130);

		// long response stall while requests keep coming, then let it all drain
		holds_asked++;
		random_items(10);
		wait_drained();

		send_idle_pct = 49;
		recv_idle_pct = 22;
		random_items(130);
		while (model.rule_count < TABLE_DEPTH)
			send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, $urandom,
				16'($urandom), $urandom, 16'($urandom)));
		// duplicate still reported as such once the table is full, fresh key reports full
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, 32'h0, 16'h0,
			32'h0, 16'h0));
		send_item(make_item(nrtl_pkg::OP_INSERT, nrtl_pkg::KIND_EXACT, $urandom, 16'($urandom),
			$urandom, 16'($urandom)));

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(130);

		wait_drained();
		repeat (100) @(posedge clk);
		if (model.mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/nrtl_pkg.sv
rtl/nrtl_rule_mem.sv
rtl/nrtl_match.sv
rtl/nat_rule_table_lookup.sv
sim/tb.sv
